### hdl/touch_point_poll_i2c_master_assert.svh
// Assertion macros used by the touch point poll I2C master RTL.
`ifndef TOUCH_POINT_POLL_I2C_MASTER_ASSERT_SVH
`define TOUCH_POINT_POLL_I2C_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPPI2C_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define TPPI2C_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### hdl/tppi2c_pkg.sv
// Package: word types and register indexes of the touch point poll I2C master.
`timescale 1ns / 1ps
`default_nettype none
package tppi2c_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_REG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_REG  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO    = 2'd3;

	localparam logic [7:0]  DEV_ADDR_RST   = 8'd186;
	localparam logic [15:0] STATUS_REG_RST = 16'd33102;
	localparam logic [15:0] POINT_REG_RST  = 16'd33104;
	localparam logic [7:0]  ACK_TMO_RST    = 8'd200;

	typedef struct packed {
		logic start_scan;
		logic sda_in;
	} tppi2c_in_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        busy_res;
		logic        point_valid;
		logic [2:0]  point_index;
		logic [15:0] point_x;
		logic [15:0] point_y;
		logic [15:0] point_size;
		logic        scan_done;
		logic        scan_found;
		logic [2:0]  touch_count;
	} tppi2c_out_t;

endpackage
`default_nettype wire

### hdl/tppi2c_obuf.sv
// Two-word result queue that decouples the sequencer from a stalling receiver.
`timescale 1ns / 1ps
`default_nettype none
module tppi2c_obuf (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire tppi2c_pkg::tppi2c_out_t  push_data,
	output logic                          full,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output tppi2c_pkg::tppi2c_out_t       out_data
);
	import tppi2c_pkg::*;

	logic [1:0]  cnt_q;
	tppi2c_out_t head_q;
	tppi2c_out_t tail_q;
	logic        pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign out_data  = head_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/touch_point_poll_i2c_master.sv
// Top level: touch point poll I2C master sequencer with config registers.
//
// Usage: every input word on in_data is one half-bit bus tick from a
// prescaler; it carries a scan request and the sampled SDA level. Each
// accepted word yields exactly one result word on out_data with the SCL/SDA
// drive levels, busy flag, touch point reports and the end-of-scan summary.
// The result for a word is written into the result queue when it is accepted.
// Throughput: one word per cycle while the result queue has space; the phase
// sequencer settles next state and result in a single combinational pass
// between its state registers and the two-word result queue.
// A stalled receiver fills the result queue; in_ready drops once two words
// wait, and the sequencer holds its state until space frees up.
// Reset returns the sequencer to idle (bus released, no scan), empties the
// queue and restores the configuration registers to their defaults.
// Configuration words on cfg_index/cfg_data are taken every cycle and must
// only be written while no scan is running and the queue is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "touch_point_poll_i2c_master_assert.svh"
module touch_point_poll_i2c_master #(
	parameter int MAX_POINTS = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire tppi2c_pkg::tppi2c_in_t             in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output tppi2c_pkg::tppi2c_out_t                 out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [tppi2c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tppi2c_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tppi2c_pkg::*;

	localparam int PE_W = $clog2(MAX_POINTS + 1);
	localparam int BC_W = $clog2(8 * MAX_POINTS + 1);
	localparam int CW   = PE_W + 3;

	typedef enum logic [4:0] {
		PH_IDLE, S_START, S_DEVW, S_REGH, S_REGL, S_STOP1, S_RSTART, S_DEVR,
		S_READ, S_STOP2, D_START, D_DEVW, D_REGH, D_REGL, D_STOP1, D_RSTART,
		D_DEVR, D_READ, D_STOP2, C_START, C_DEVW, C_REGH, C_REGL, C_DATA,
		C_STOP
	} phase_t;

	typedef enum logic [2:0] {
		K_NONE, K_START, K_STOP, K_READ, K_WRITE
	} kind_t;

	function automatic kind_t phase_kind(input phase_t p);
		kind_t k;
		unique case (p)
			S_START, S_RSTART, D_START, D_RSTART, C_START: k = K_START;
			S_STOP1, S_STOP2, D_STOP1, D_STOP2, C_STOP:    k = K_STOP;
			S_READ, D_READ:                                k = K_READ;
			S_DEVW, S_REGH, S_REGL, S_DEVR, D_DEVW, D_REGH, D_REGL, D_DEVR,
			C_DEVW, C_REGH, C_REGL, C_DATA:                k = K_WRITE;
			default:                                       k = K_NONE;
		endcase
		return k;
	endfunction

	// configuration registers
	logic [7:0]  dev_addr_q;
	logic [15:0] status_reg_q;
	logic [15:0] point_reg_q;
	logic [7:0]  ack_tmo_q;

	// sequencer state
	phase_t          phase_q;
	logic [3:0]      bit_q;
	logic            half_q;
	logic            abort_q;
	logic [7:0]      shift_q;
	logic [BC_W-1:0] byte_q;
	logic [7:0]      poll_q;
	logic [7:0]      status_q;
	logic [PE_W-1:0] pts_q;
	logic [15:0]     x_q;
	logic [15:0]     y_q;
	logic [7:0]      szl_q;

	phase_t          nx_phase;
	logic [3:0]      nx_bit;
	logic            nx_half;
	logic            nx_abort;
	logic [7:0]      nx_shift;
	logic [BC_W-1:0] nx_byte;
	logic [7:0]      nx_poll;
	logic [7:0]      nx_status;
	logic [PE_W-1:0] nx_pts;
	logic [15:0]     nx_x;
	logic [15:0]     nx_y;
	logic [7:0]      nx_szl;

	phase_t          ph;
	kind_t           kind;
	logic [3:0]      bc;
	logic            hf;
	logic            ab;
	logic [PE_W-1:0] pe;
	logic            launch;
	logic            active;
	logic            goto_en;
	phase_t          goto_ph;
	logic [7:0]      wv;
	logic [7:0]      rd_byte;
	logic [CW-1:0]   byte_inc;
	logic [CW-1:0]   byte_total;
	logic [8:0]      poll_inc;
	logic [3:0]      st_cnt;
	tppi2c_out_t     res;
	logic            accept;
	logic            buf_full;

	assign accept   = in_valid && in_ready;
	assign in_ready = !buf_full;
	assign cfg_ready = 1'b1;

	always_comb begin
		launch = (phase_kind(phase_q) == K_NONE) && in_data.start_scan;
		active = (phase_kind(phase_q) != K_NONE) || in_data.start_scan;
		ph     = launch ? S_START : phase_q;
		kind   = phase_kind(ph);
		bc     = launch ? 4'd0 : bit_q;
		hf     = launch ? 1'b0 : half_q;
		ab     = launch ? 1'b0 : abort_q;
		pe     = launch ? '0 : pts_q;

		nx_phase  = ph;
		nx_bit    = bc;
		nx_half   = hf;
		nx_abort  = ab;
		nx_shift  = shift_q;
		nx_byte   = byte_q;
		nx_poll   = poll_q;
		nx_status = status_q;
		nx_pts    = pe;
		nx_x      = x_q;
		nx_y      = y_q;
		nx_szl    = szl_q;
		goto_en   = 1'b0;
		goto_ph   = ph;

		res           = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;

		rd_byte    = {shift_q[6:0], in_data.sda_in};
		byte_inc   = CW'(byte_q) + CW'(1);
		byte_total = {pts_q, 3'b000};
		poll_inc   = {1'b0, poll_q} + 9'd1;
		st_cnt     = status_q[3:0];

		unique case (ph)
			S_DEVW, D_DEVW, C_DEVW: wv = dev_addr_q;
			S_DEVR, D_DEVR:         wv = dev_addr_q | 8'h01;
			S_REGH, C_REGH:         wv = status_reg_q[15:8];
			S_REGL, C_REGL:         wv = status_reg_q[7:0];
			D_REGH:                 wv = point_reg_q[15:8];
			D_REGL:                 wv = point_reg_q[7:0];
			default:                wv = 8'h00;
		endcase

		if (!active) begin
			nx_phase = PH_IDLE;
		end else begin
			res.busy_res = 1'b1;
			if (ab) begin
				// forced STOP after an ACK timeout, then carry on
				res.scl_level = (bc != 4'd0);
				res.sda_level = (bc == 4'd2);
				if (bc >= 4'd2) begin
					nx_abort = 1'b0;
					goto_en  = 1'b1;
					goto_ph  = phase_t'(ph + 5'd1);
				end else begin
					nx_bit = bc + 4'd1;
				end
			end else begin
				unique case (kind)
					K_START: begin
						res.scl_level = (bc != 4'd2);
						res.sda_level = (bc == 4'd0);
						if (bc >= 4'd2) begin
							goto_en = 1'b1;
							goto_ph = phase_t'(ph + 5'd1);
						end else begin
							nx_bit = bc + 4'd1;
						end
					end
					K_STOP: begin
						res.scl_level = (bc != 4'd0);
						res.sda_level = (bc == 4'd2);
						if (bc >= 4'd2) begin
							goto_en = 1'b1;
							priority if (ph == S_STOP2) begin
								if (!status_q[7]) begin
									res.scan_done = 1'b1;
									goto_ph       = PH_IDLE;
								end else if (st_cnt != 4'd0 && 32'(st_cnt) <= MAX_POINTS) begin
									nx_pts  = PE_W'(st_cnt);
									goto_ph = D_START;
								end else begin
									goto_ph = C_START;
								end
							end else if (ph == D_STOP2) begin
								goto_ph = C_START;
							end else if (ph == C_STOP) begin
								res.scan_done   = 1'b1;
								res.scan_found  = (pe != '0);
								res.touch_count = 3'(pe);
								goto_ph         = PH_IDLE;
							end else begin
								goto_ph = phase_t'(ph + 5'd1);
							end
						end else begin
							nx_bit = bc + 4'd1;
						end
					end
					K_READ: begin
						res.scl_level = hf;
						if (bc < 4'd8) begin
							if (hf) begin
								nx_shift = rd_byte;
								nx_half  = 1'b0;
								nx_bit   = bc + 4'd1;
								if (bc == 4'd7) begin
									if (ph != D_READ) begin
										nx_status = rd_byte;
									end else begin
										unique case (byte_q[2:0])
											3'd1: nx_x[7:0]  = rd_byte;
											3'd2: nx_x[15:8] = rd_byte;
											3'd3: nx_y[7:0]  = rd_byte;
											3'd4: nx_y[15:8] = rd_byte;
											3'd5: nx_szl     = rd_byte;
											3'd6: begin
												res.point_valid = 1'b1;
												res.point_index = 3'(byte_q[BC_W-1:3]);
												res.point_x     = x_q;
												res.point_y     = y_q;
												res.point_size  = {rd_byte, szl_q};
											end
											default: ;
										endcase
									end
								end
							end else begin
								nx_half = 1'b1;
							end
						end else begin
							// ACK all record bytes but the last, NACK the status byte
							res.sda_level = (ph != D_READ) || (byte_inc >= byte_total);
							if (hf) begin
								if (ph != D_READ) begin
									goto_en = 1'b1;
									goto_ph = phase_t'(ph + 5'd1);
								end else begin
									nx_byte = BC_W'(byte_inc);
									if (byte_inc >= byte_total) begin
										goto_en = 1'b1;
										goto_ph = D_STOP2;
									end else begin
										nx_bit  = 4'd0;
										nx_half = 1'b0;
									end
								end
							end else begin
								nx_half = 1'b1;
							end
						end
					end
					K_WRITE: begin
						if (bc < 4'd8) begin
							res.scl_level = hf;
							res.sda_level = wv[3'd7 - bc[2:0]];
							if (hf) begin
								nx_half = 1'b0;
								nx_bit  = bc + 4'd1;
							end else begin
								nx_half = 1'b1;
							end
						end else if (!hf) begin
							res.scl_level = 1'b0;
							nx_poll       = 8'd0;
							nx_half       = 1'b1;
						end else begin
							// poll the ACK with SCL held high
							if (!in_data.sda_in) begin
								goto_en = 1'b1;
								goto_ph = phase_t'(ph + 5'd1);
							end else if (poll_inc > {1'b0, ack_tmo_q}) begin
								nx_abort = 1'b1;
								nx_bit   = 4'd0;
								nx_half  = 1'b0;
							end else begin
								nx_poll = poll_inc[7:0];
							end
						end
					end
					default: ;
				endcase
			end
		end

		if (goto_en) begin
			nx_phase = goto_ph;
			nx_bit   = 4'd0;
			nx_half  = 1'b0;
			if (goto_ph == D_READ) begin
				nx_byte = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= 4'd0;
			half_q   <= 1'b0;
			abort_q  <= 1'b0;
			shift_q  <= 8'd0;
			byte_q   <= '0;
			poll_q   <= 8'd0;
			status_q <= 8'd0;
			pts_q    <= '0;
			x_q      <= 16'd0;
			y_q      <= 16'd0;
			szl_q    <= 8'd0;
		end else if (accept) begin
			phase_q  <= nx_phase;
			bit_q    <= nx_bit;
			half_q   <= nx_half;
			abort_q  <= nx_abort;
			shift_q  <= nx_shift;
			byte_q   <= nx_byte;
			poll_q   <= nx_poll;
			status_q <= nx_status;
			pts_q    <= nx_pts;
			x_q      <= nx_x;
			y_q      <= nx_y;
			szl_q    <= nx_szl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= DEV_ADDR_RST;
			status_reg_q <= STATUS_REG_RST;
			point_reg_q  <= POINT_REG_RST;
			ack_tmo_q    <= ACK_TMO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEV_ADDR:   dev_addr_q   <= cfg_data[7:0];
				CFG_STATUS_REG: status_reg_q <= cfg_data;
				CFG_POINT_REG:  point_reg_q  <= cfg_data;
				CFG_ACK_TMO:    ack_tmo_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tppi2c_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`TPPI2C_ASSERT_NEXT(a_idle_holds, accept && phase_q == PH_IDLE && !in_data.start_scan, phase_q == PH_IDLE)
	`TPPI2C_ASSERT_NEXT(a_done_to_idle, accept && res.scan_done, phase_q == PH_IDLE && !abort_q)
	`TPPI2C_ASSERT_NOW(a_point_in_read, accept && res.point_valid, phase_q == D_READ && half_q && !res.scan_done)
	`TPPI2C_ASSERT_NOW(a_abort_bounded, abort_q, phase_q != PH_IDLE && bit_q <= 4'd2)
	`TPPI2C_ASSERT_NOW(a_points_bounded, 1'b1, 32'(pts_q) <= MAX_POINTS)

endmodule
`default_nettype wire
